### rtl/etf_pkg.sv
// etf_pkg: constants, types and helpers for the escape-time fractal iteration block.
// No dependencies. Used by every module in rtl/.
package etf_pkg;

   localparam int FractionBits = 124;
   localparam int CountBits    = 32;
   localparam int WordBits     = 128;
   localparam int ProdBits     = 256;
   localparam int DigitBits    = 8;

   localparam logic [0:0] CsrLimit   = 1'b0;
   localparam logic [0:0] CsrVariant = 1'b1;

   localparam logic [31:0] LimitReset = 32'd256;

endpackage

### rtl/etf_serial_mul.sv
// etf_serial_mul: signed 128x128 multiplier, one 8-bit digit of b per cycle.
// Returns floor(a*b / 2^FRACTION_BITS) at 256 bits. Depends on etf_pkg.
module etf_serial_mul #(
   parameter int FRACTION_BITS = etf_pkg::FractionBits
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [etf_pkg::WordBits-1:0] a,
   input  logic signed [etf_pkg::WordBits-1:0] b,
   output logic                          done,
   output logic signed [etf_pkg::ProdBits-1:0] prod
);
   localparam int Steps   = etf_pkg::WordBits / etf_pkg::DigitBits;
   localparam int StepW   = $clog2(Steps + 1);
   localparam int AccW    = etf_pkg::WordBits + etf_pkg::DigitBits + 2;
   localparam int D       = etf_pkg::DigitBits;

   logic [StepW-1:0]                 step_ff, step_in;
   logic                             busy_ff, busy_in, done_ff, done_in;
   logic signed [AccW-1:0]           acc_ff, acc_in;
   logic [etf_pkg::WordBits-1:0]     low_ff, low_in;
   logic [etf_pkg::WordBits-1:0]     b_ff, b_in;
   logic signed [etf_pkg::WordBits-1:0] a_ff, a_in;
   logic signed [D+1:0]              digit;
   logic signed [AccW-1:0]           part;
   logic signed [AccW-1:0]           sum;
   logic                             last;

   // last digit is signed, earlier digits unsigned
   assign last  = (step_ff == StepW'(Steps - 1));
   assign digit = last ? {{2{b_ff[D-1]}}, b_ff[D-1:0]} : {2'b00, b_ff[D-1:0]};
   assign part  = AccW'(a_ff) * AccW'(digit);
   assign sum   = acc_ff + part;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      low_in  = low_ff;
      b_in    = b_ff;
      a_in    = a_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = '0;
         low_in  = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         acc_in  = sum >>> D;
         low_in  = {sum[D-1:0], low_ff[etf_pkg::WordBits-1:D]};
         b_in    = b_ff >> D;
         step_in = step_ff + StepW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      low_ff <= low_in;
      b_ff   <= b_in;
      a_ff   <= a_in;
   end

   assign done = done_ff;
   assign prod = $signed({acc_ff[etf_pkg::WordBits-1:0], low_ff}) >>> FRACTION_BITS;
endmodule

### rtl/escape_time_fractal_iteration.sv
// escape_time_fractal_iteration: top level, sequencer around one digit-serial multiplier.
// Depends on etf_pkg and etf_serial_mul.
//
// channel | ports  | direction | content
// req     | req_*  | in        | c, start z, start count, pending, lane_valid
// rsp     | rsp_*  | out       | final z, count, escaped
// csr     | csr_*  | in        | iteration_limit (0), fractal_variant (1)
//
// One iteration runs five 128x128 products on the shared multiplier, each made of a
// start, 16 digits and a capture, plus one update state.
// rsp_valid rises once the limit stops the pixel or it escapes; a pass-through pixel
// skips the iterations.
// Reset is synchronous; limit returns to 256, variant to Mandelbrot.
// One transaction at a time; rsp holds while rsp_ready is low, req_ready returns
// the cycle after the rsp transaction.
module escape_time_fractal_iteration #(
   parameter int FRACTION_BITS = etf_pkg::FractionBits,
   parameter int COUNT_BITS    = etf_pkg::CountBits
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [63:0] req_point_re_high,
   input  logic [63:0]        req_point_re_low,
   input  logic signed [63:0] req_point_im_high,
   input  logic [63:0]        req_point_im_low,
   input  logic signed [63:0] req_start_re_high,
   input  logic [63:0]        req_start_re_low,
   input  logic signed [63:0] req_start_im_high,
   input  logic [63:0]        req_start_im_low,
   input  logic [31:0]        req_start_count,
   input  logic               req_pending,
   input  logic               req_lane_valid,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_end_re_high,
   output logic [63:0]        rsp_end_re_low,
   output logic signed [63:0] rsp_end_im_high,
   output logic [63:0]        rsp_end_im_low,
   output logic [31:0]        rsp_end_count,
   output logic               rsp_escaped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int W = etf_pkg::WordBits;
   localparam int P = etf_pkg::ProdBits;

   localparam logic [2:0] StIdle = 3'd0, StXX = 3'd1, StYY = 3'd2, StXY = 3'd3,
                          StUpd = 3'd4, StX2 = 3'd5, StY2 = 3'd6, StOut = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [COUNT_BITS-1:0]   limit_ff, limit_in, count_ff, count_in;
   logic                    ship_ff, ship_in, esc_ff, esc_in, rsp_valid_ff, rsp_valid_in;
   logic                    issued_ff, issued_in;
   logic signed [W-1:0]     x_ff, x_in, y_ff, y_in, cr_ff, cr_in, ci_ff, ci_in;
   logic signed [P-1:0]     t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic signed [W-1:0]     ma, mb;
   logic signed [P-1:0]     prod;
   logic                    mdone;
   logic                    mul_start;
   logic signed [P-1:0]     nx, ny, xy_abs, dsum, four;
   logic                    go;

   etf_serial_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(ma), .b(mb), .done(mdone), .prod(prod));

   function automatic logic signed [W-1:0] sat(input logic signed [P-1:0] v);
      logic hi_ok;
      hi_ok = (v[P-1:W-1] == '0) || (v[P-1:W-1] == '1);
      if (hi_ok) return v[W-1:0];
      return v[P-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   endfunction

   assign four   = P'(1) << (FRACTION_BITS + 2);
   assign xy_abs = (ship_ff && t2_ff[P-1]) ? -t2_ff : t2_ff;
   assign nx     = t0_ff - t1_ff + P'(cr_ff);
   assign ny     = (xy_abs <<< 1) + P'(ci_ff);
   assign dsum   = t0_ff + prod - four;
   assign go     = (state_ff == StIdle) && !rsp_valid_ff;

   assign req_ready = go;
   assign csr_ready = 1'b1;

   always_comb begin
      ma = x_ff; mb = x_ff;
      case (state_ff)
         StYY:    begin ma = y_ff; mb = y_ff; end
         StXY:    begin ma = x_ff; mb = y_ff; end
         StY2:    begin ma = y_ff; mb = y_ff; end
         default: begin ma = x_ff; mb = x_ff; end
      endcase
   end

   always_comb begin
      state_in = state_ff; limit_in = limit_ff; ship_in = ship_ff;
      count_in = count_ff; esc_in = esc_ff; rsp_valid_in = rsp_valid_ff;
      x_in = x_ff; y_in = y_ff; cr_in = cr_ff; ci_in = ci_ff;
      t0_in = t0_ff; t1_in = t1_ff; t2_in = t2_ff;
      issued_in = issued_ff; mul_start = 1'b0;
      if (csr_valid) begin
         if (csr_index == etf_pkg::CsrLimit) limit_in = csr_data[COUNT_BITS-1:0];
         else ship_in = csr_data[0];
      end
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         StIdle: begin
            if (req_valid && go) begin
               cr_in = {req_point_re_high, req_point_re_low};
               ci_in = {req_point_im_high, req_point_im_low};
               x_in  = {req_start_re_high, req_start_re_low};
               y_in  = {req_start_im_high, req_start_im_low};
               count_in = req_start_count[COUNT_BITS-1:0];
               issued_in = 1'b0;
               if (!req_lane_valid) begin
                  esc_in = !req_pending; state_in = StOut;
               end else if (!req_pending) begin
                  esc_in = 1'b1; state_in = StOut;
               end else begin
                  esc_in = 1'b0; state_in = StXX;
               end
            end
         end
         StXX, StYY, StXY, StX2, StY2: begin
            if (state_ff == StXX && !issued_ff && count_ff >= limit_ff) begin
               state_in = StOut;
            end else if (!issued_ff) begin
               mul_start = 1'b1; issued_in = 1'b1;
            end else if (mdone) begin
               issued_in = 1'b0;
               case (state_ff)
                  StXX: begin t0_in = prod; state_in = StYY; end
                  StYY: begin t1_in = prod; state_in = StXY; end
                  StXY: begin t2_in = prod; state_in = StUpd; end
                  StX2: begin t0_in = prod; state_in = StY2; end
                  default: begin
                     count_in = count_ff + COUNT_BITS'(1);
                     if (!dsum[P-1] && dsum != '0) begin
                        esc_in = 1'b1; state_in = StOut;
                     end else begin
                        state_in = StXX;
                     end
                  end
               endcase
            end
         end
         StUpd: begin
            x_in = sat(nx); y_in = sat(ny); state_in = StX2;
         end
         StOut: begin
            rsp_valid_in = 1'b1; state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         limit_ff     <= etf_pkg::LimitReset[COUNT_BITS-1:0];
         ship_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issued_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         ship_ff      <= ship_in;
         rsp_valid_ff <= rsp_valid_in;
         issued_ff    <= issued_in;
      end
      count_ff <= count_in; esc_ff <= esc_in;
      x_ff <= x_in; y_ff <= y_in; cr_ff <= cr_in; ci_ff <= ci_in;
      t0_ff <= t0_in; t1_ff <= t1_in; t2_ff <= t2_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_end_re_high = x_ff[W-1:64];
   assign rsp_end_re_low  = x_ff[63:0];
   assign rsp_end_im_high = y_ff[W-1:64];
   assign rsp_end_im_low  = y_ff[63:0];
   assign rsp_end_count   = 32'(count_ff);
   assign rsp_escaped     = esc_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_end_count))
      else $error("result changed under stall");
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mul_start) else $error("multiplier started while idle");
endmodule
